>>> hdl/sem_pkg.sv
// Shared constants for the Sobel edge magnitude block.
package sem_pkg;

  // Line store geometry.
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);

  // Field widths.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned MAG_W   = 8;

  // Gradient sums are within +/-1020, squares sum below 2^21.
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned SQ_W   = 21;

  // Geometry limits.
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_VAL  = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL  = WIDTH_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]   MIN_HEIGHT_VAL = ROW_W'(3);
  localparam logic [WIDTH_W-1:0] RST_WIDTH      = WIDTH_W'(1024);
  localparam logic [ROW_W-1:0]   RST_HEIGHT     = ROW_W'(768);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

endpackage

>>> hdl/sem_isqrt.sv
// Iterative floor square root, saturated to 8 bits, one result bit per cycle.
module sem_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sem_pkg::SQ_W-1:0]  value_i,
  output logic                      done_o,
  output logic [sem_pkg::MAG_W-1:0] root_o
);
  import sem_pkg::*;

  localparam int unsigned VAL_W = 2 * MAG_W;
  localparam int unsigned REM_W = MAG_W + 2;
  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic [VAL_W-1:0] val_q;
  logic [REM_W-1:0] rem_q;
  logic [MAG_W-1:0] root_q;
  logic             sat_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [REM_W+1:0] rem_n;
  logic [REM_W+1:0] trial;
  logic             take;

  // One digit of the restoring root per cycle.
  assign rem_n = {rem_q, val_q[VAL_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = (rem_n >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i[VAL_W-1:0];
      sat_q  <= |value_i[SQ_W-1:VAL_W];
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[VAL_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= REM_W'(rem_n - trial);
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[REM_W-1:0];
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = sat_q ? {MAG_W{1'b1}} : root_q;

endmodule

>>> hdl/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Usage:
//  - Pixels enter in raster order on in_valid_i / pixel_value_i; a transfer
//    happens on a rising edge with in_valid_i high and in_stall_o low.
//  - Each interior pixel (window centre not on the border) gives one result
//    on out_valid_o with its centre row and column; border pixels give none.
//    frame_last_o marks the final interior result of a frame.
//  - Geometry is set through cfg_we_i / cfg_index_i / cfg_data_i while idle.
//    A width below 3 acts as 3, above 1024 as 1024; a height below 3 as 3.
// Timing:
//  - One pixel is in work at a time. A pixel whose window is on the border
//    goes through the line store read, then the write-back.
//  - An interior pixel goes through read, sums, squares, sqrt load, the
//    bit-serial root unit, then the output register load.
//  - The result sits in an output register; a new pixel is taken while it
//    waits. If the receiver stalls, the next interior result holds in the
//    emit state until the register frees.
// Reset: counters, window and config registers clear to width 1024, height
// 768; the line stores are not cleared, no clearing pass is needed.
module sobel_edge_magnitude (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sem_pkg::MAG_W-1:0]       edge_magnitude_o,
  output logic [sem_pkg::ROW_W-1:0]       center_row_o,
  output logic [sem_pkg::COL_W-1:0]       center_col_o,
  output logic                            frame_last_o
);
  import sem_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_START  = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // Configuration
  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < MIN_WIDTH_VAL) begin
      w_eff = MIN_WIDTH_VAL;
    end else if (width_q > MAX_WIDTH_VAL) begin
      w_eff = MAX_WIDTH_VAL;
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < MIN_HEIGHT_VAL) ? MIN_HEIGHT_VAL : height_q;
  end

  // Control
  logic [2:0]       state_q, state_d;
  logic             in_xfer;
  logic             out_xfer;
  logic             out_free;
  logic             sq_start;
  logic             sq_done;
  logic [MAG_W-1:0] sq_root;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign sq_start   = (state_q == ST_START);

  // Position counters
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [WIDTH_W-1:0] col_inc;
  logic [ROW_W:0]     row_inc;

  assign col_inc = {1'b0, col_q} + WIDTH_W'(1);
  assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (col_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_q <= col_inc[COL_W-1:0];
      end
    end
  end

  // Per-item context captured at the transfer
  logic [PIX_W-1:0]  pix_q;
  logic [ADDR_W-1:0] addr_q;
  logic              interior_q;
  logic [ROW_W-1:0]  crow_q;
  logic [COL_W-1:0]  ccol_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q      <= pixel_value_i;
      addr_q     <= col_q[ADDR_W-1:0];
      interior_q <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      crow_q     <= row_q - ROW_W'(1);
      ccol_q     <= col_q - COL_W'(1);
      last_q     <= (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);
    end
  end

  // Line stores: read at the transfer, written back in the read state
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic             mem_we;

  assign mem_we = (state_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[addr_q]  <= mid_q;
      middle_mem[addr_q] <= pix_q;
    end
    if (in_xfer) begin
      top_q <= upper_mem[col_q[ADDR_W-1:0]];
      mid_q <= middle_mem[col_q[ADDR_W-1:0]];
    end
  end

  // Window: [0..2] left column, [3..5] middle column; top, mid, bottom
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (mem_we) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_q;
      win_q[4] <= mid_q;
      win_q[5] <= pix_q;
    end
  end

  // Gradient sums
  logic [GRAD_W-2:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] sx_q, sy_q;

  always_comb begin
    gx_pos = {2'b00, top_q} + {1'b0, mid_q, 1'b0} + {2'b00, pix_q};
    gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
    gy_pos = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, top_q};
    gy_neg = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, pix_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sx_q <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      sy_q <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end
  end

  // Squares
  logic signed [2*GRAD_W-1:0] sx_sq, sy_sq;
  logic [SQ_W-1:0]            sq_q;

  assign sx_sq = sx_q * sx_q;
  assign sy_sq = sy_q * sy_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQUARE) begin
      sq_q <= {1'b0, sx_sq[SQ_W-2:0]} + {1'b0, sy_sq[SQ_W-2:0]};
    end
  end

  sem_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_READ;
      ST_READ:   state_d = interior_q ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_d = ST_START;
      ST_START:  state_d = ST_WAIT;
      ST_WAIT:   if (sq_done) state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  logic             out_valid_q;
  logic             out_load;
  logic [MAG_W-1:0] mag_q;
  logic [ROW_W-1:0] orow_q;
  logic [COL_W-1:0] ocol_q;
  logic             olast_q;

  assign out_load = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mag_q   <= sq_root;
      orow_q  <= crow_q;
      ocol_q  <= ccol_q;
      olast_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = mag_q;
  assign center_row_o     = orow_q;
  assign center_col_o     = ocol_q;
  assign frame_last_o     = olast_q;

endmodule

>>> verif/sem_tb_pkg.sv
// Edge magnitude predictor and queue of expected results for the Sobel testbench.
package sem_tb_pkg;
  import sem_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } edge_result_t;

  class edge_magnitude_model;
    logic [PIX_W-1:0]   upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_line [MAX_WIDTH];
    // 0..2 left column, 3..5 middle column; top, mid, bottom
    logic [PIX_W-1:0]   win [6];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    edge_result_t       expected_edges [$];
    int unsigned        mismatches;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_WIDTH_VAL) return MIN_WIDTH_VAL;
      if (width_reg > MAX_WIDTH_VAL) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_HEIGHT_VAL) return MIN_HEIGHT_VAL;
      return height_reg;
    endfunction

    function int unsigned isqrt(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 11; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Pixels still to come before the counters are back at the frame start.
    function int unsigned pixels_to_frame_end(int unsigned cap);
      int unsigned c, r, n, w, h;
      c = col_pos;
      r = row_pos;
      n = 0;
      w = eff_width();
      h = eff_height();
      do begin
        if (c + 1 >= w) begin
          c = 0;
          r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          c++;
        end
        n++;
      end while ((c != 0 || r != 0) && n <= cap);
      return n;
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix);
      int unsigned  w, h, mag;
      int           top, mid, bot, sx, sy;
      edge_result_t res;
      w   = eff_width();
      h   = eff_height();
      top = int'(upper_line[col_pos]);
      mid = int'(middle_line[col_pos]);
      bot = int'(pix);
      if (row_pos >= 2 && col_pos >= 2) begin
        sx = (top + 2 * mid + bot) - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        sy = (int'(win[0]) + 2 * int'(win[3]) + top) - (int'(win[2]) + 2 * int'(win[5]) + bot);
        mag = isqrt(sx * sx + sy * sy);
        if (mag > 255) mag = 255;
        res.magnitude = MAG_W'(mag);
        res.row       = ROW_W'(row_pos - 1);
        res.col       = COL_W'(col_pos - 1);
        res.last      = (row_pos + 1 == h) && (col_pos + 1 == w);
        expected_edges.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(top);
      win[4] = PIX_W'(mid);
      win[5] = pix;
      upper_line[col_pos]  = PIX_W'(mid);
      middle_line[col_pos] = pix;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 25) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task match_edge(edge_result_t got);
      edge_result_t want;
      if (expected_edges.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: row %0d col %0d mag %0d",
                                got.row, got.col, got.magnitude));
        return;
      end
      want = expected_edges.pop_front();
      if (got.magnitude !== want.magnitude)
        flag_mismatch($sformatf("magnitude %0d, want %0d at row %0d col %0d",
                                got.magnitude, want.magnitude, want.row, want.col));
      if (got.row !== want.row)
        flag_mismatch($sformatf("center_row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        flag_mismatch($sformatf("center_col %0d, want %0d", got.col, want.col));
      if (got.last !== want.last)
        flag_mismatch($sformatf("frame_last %0b, want %0b at row %0d col %0d",
                                got.last, want.last, want.row, want.col));
    endtask

    task close_out();
      if (expected_edges.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", expected_edges.size()));
    endtask
  endclass

endpackage

>>> verif/tb.sv
// Testbench top: drives pixel frames into the Sobel block and checks every edge result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;
  import sem_tb_pkg::*;

  // Watchdog limit on the run length.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Border pixels make no result, so after the last result wait this long for
  // any pixel still in work before touching the geometry.
  localparam int unsigned DRAIN_CYCLES  = 32;
  localparam int unsigned RANDOM_PIXELS = 1000;
  // Widest row used after the line store fill; random widths stay within it.
  localparam int unsigned FILL_WIDTH    = 64;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [MAG_W-1:0]      edge_magnitude_o;
  logic [ROW_W-1:0]      center_row_o;
  logic [COL_W-1:0]      center_col_o;
  logic                  frame_last_o;

  edge_magnitude_model edge_pred = new();
  int unsigned         cycle_count = 0;
  int unsigned         burst_left = 0;

  sobel_edge_magnitude u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_value_i    (pixel_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_magnitude_o (edge_magnitude_o),
    .center_row_o     (center_row_o),
    .center_col_o     (center_col_o),
    .frame_last_o     (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure. Each phase picks a mode: no stall, light random,
  // a fixed duty pattern, or heavy random stalls.
  initial begin
    int unsigned phase_left;
    int unsigned mode;
    phase_left = 0;
    mode       = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(50, 400);
      end
      phase_left--;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        2:       out_stall_i <= ((phase_left % 6) < 2);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result monitor: sampled before this edge's updates land.
  always @(posedge clk_i) begin
    edge_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {edge_magnitude_o, center_row_o, center_col_o, frame_last_o};
      edge_pred.match_edge(seen);
    end
  end

  // One pixel transfer. Bursts of random length, with a random gap (often
  // none) in front of each burst. Called and returns right after an edge.
  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    edge_pred.take_pixel(pix);
  endtask

  // Both geometry registers, back to back; only while the block is idle.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    edge_pred.write_reg(CFG_IMAGE_WIDTH, w);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    edge_pred.write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // Hold off until every expected result is in, then let any border pixel
  // still in work finish.
  task automatic settle();
    while (edge_pred.expected_edges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Pixel content styles: uniform noise, black/white only (saturating
  // gradients), a gentle ramp (small gradients), and values near 0x00, 0x80 and 0xFF.
  function automatic logic [PIX_W-1:0] pick_pixel(int unsigned style, int unsigned k);
    case (style)
      0:       return PIX_W'($urandom_range(0, 255));
      1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2:       return PIX_W'(k * 5 + $urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 5))
          0:       return 8'h00;
          1:       return 8'h01;
          2:       return 8'h7F;
          3:       return 8'h80;
          4:       return 8'hFE;
          default: return 8'hFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_run(input int unsigned count, input int unsigned style);
    for (int unsigned k = 0; k < count; k++) push_pixel(pick_pixel(style, k));
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0]      step_edge [9];
    logic [PIX_W-1:0]      bit_walk [9];
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    int unsigned           sent;
    int unsigned           n;

    step_edge = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
    bit_walk  = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFF};

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_IMAGE_WIDTH;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    pixel_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, one interior pixel: hard vertical and horizontal step,
    // the gradient saturates and the lone result is the frame's last.
    set_geometry(12'd3, 12'd3);
    foreach (step_edge[i]) push_pixel(step_edge[i]);
    in_valid_i <= 1'b0;
    settle();

    // Sizes below the minimum act as 3x3; flat black gives zero magnitude.
    set_geometry(12'd1, 12'd0);
    for (int i = 0; i < 9; i++) push_pixel(8'h00);
    in_valid_i <= 1'b0;
    settle();

    // Width bit 11 falls outside the 11-bit register: 0x802 is width 2 -> 3.
    set_geometry(12'h802, 12'd1);
    foreach (bit_walk[i]) push_pixel(bit_walk[i]);
    in_valid_i <= 1'b0;
    settle();

    // Line store fill: three full rows of the widest random width plus part
    // of a fourth write every column that later runs can reach, so a width
    // raised part way through a frame never reads a stale entry.
    set_geometry(CFG_DATA_W'(FILL_WIDTH), 12'hFFF);
    send_run(3 * FILL_WIDTH + 40, 0);
    settle();

    // Shrink mid-frame: column 40 and row 3 sit beyond the new 7x3 (height 2
    // acts as 3), so the next pixel wraps both counters to the frame start.
    set_geometry(12'd7, 12'd2);
    send_run(1, 1);
    settle();

    // Random geometry and content. Most runs finish the frame from wherever
    // the counters stand; some stop part way so the next geometry lands
    // mid-frame.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 15))
        0:       w_raw = CFG_DATA_W'($urandom_range(0, 2));
        1:       w_raw = 12'h800 | CFG_DATA_W'($urandom_range(3, 12));
        2, 3:    w_raw = CFG_DATA_W'($urandom_range(13, FILL_WIDTH));
        default: w_raw = CFG_DATA_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 11))
        0:       h_raw = CFG_DATA_W'($urandom_range(0, 2));
        1:       h_raw = CFG_DATA_W'($urandom_range(9, 4095));
        default: h_raw = CFG_DATA_W'($urandom_range(3, 8));
      endcase
      set_geometry(w_raw, h_raw);
      n = edge_pred.pixels_to_frame_end(300);
      if (n > 300 || $urandom_range(0, 4) == 0) n = $urandom_range(1, 40);
      send_run(n, $urandom_range(0, 3));
      sent += n;
      settle();
    end

    edge_pred.close_out();
    if (edge_pred.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
